// ----- design/assert_macros.svh -----
// Assertion macros for the LBP 3x3 stream core.
// Uses the clk and rst_n names of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset
`define LBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset
`define LBP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LBP_ASSERT(lbl, prop, msg)
`define LBP_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- design/lbp3_pkg.sv -----
// Shared types and constants for the LBP 3x3 stream core.
// No dependencies; referenced by the interfaces and imported by all modules.
package lbp3_pkg;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 11;
  localparam int CODE_W = 8;

  // Configuration register widths and limits
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_THRESH_W = 10;
  localparam int CFG_AW       = 4;
  localparam int CFG_DW       = 32;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_THRESH_W-1:0] THRESH_RESET = 10'd0;
  localparam int WIDTH_MIN  = 3;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_MIN = 13'd3;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_MAX = 13'd4096;

  // Register word indexes on the configuration port
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_t;

  // Code bit positions, right then clockwise
  localparam int BIT_RIGHT       = 0;
  localparam int BIT_LOWER_RIGHT = 1;
  localparam int BIT_BELOW       = 2;
  localparam int BIT_LOWER_LEFT  = 3;
  localparam int BIT_LEFT        = 4;
  localparam int BIT_UPPER_LEFT  = 5;
  localparam int BIT_UP          = 6;
  localparam int BIT_UPPER_RIGHT = 7;

  typedef struct packed {
    logic [CFG_WIDTH_W-1:0]         image_width;
    logic [CFG_HEIGHT_W-1:0]        image_height;
    logic signed [CFG_THRESH_W-1:0] diff_threshold;
  } cfg_t;

  // Window control from the pipeline to the window unit
  typedef struct packed {
    logic shift;   // item leaves the compare stage this cycle
    logic border;  // pixel in row 0/1 or column 0/1: force code to zero
  } win_ctl_t;

endpackage

// ----- design/lbp3_pix_if.sv -----
// Input channel: one grayscale pixel per item.
// Depends on lbp3_pkg for the pixel width.
interface lbp3_pix_if;
  logic                       valid;
  logic                       ready;
  logic [lbp3_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

// ----- design/lbp3_code_if.sv -----
// Result channel: centre coordinates and its 8-bit pattern.
// Depends on lbp3_pkg for the field widths.
interface lbp3_code_if;
  logic                        valid;
  logic                        ready;
  logic [lbp3_pkg::ROW_W-1:0]  out_row;
  logic [lbp3_pkg::COL_W-1:0]  out_col;
  logic [lbp3_pkg::CODE_W-1:0] code;

  modport source (output valid, output out_row, output out_col, output code, input ready);
  modport sink (input valid, input out_row, input out_col, input code, output ready);
endinterface

// ----- design/lbp3_line_mem.sv -----
// One line buffer: single write port, one registered read port.
// Depends on lbp3_pkg for the pixel width.
module lbp3_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [lbp3_pkg::PIX_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [lbp3_pkg::PIX_W-1:0] rdata
);
  import lbp3_pkg::*;

  logic [PIX_W-1:0] mem_r [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read; hold the data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/lbp3_window.sv -----
// 3x3 window registers and the neighbour-minus-centre compare.
// Depends on lbp3_pkg for widths, bit positions and win_ctl_t.
module lbp3_window (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lbp3_pkg::win_ctl_t                ctl,
  input  logic [lbp3_pkg::PIX_W-1:0]        top,
  input  logic [lbp3_pkg::PIX_W-1:0]        mid,
  input  logic [lbp3_pkg::PIX_W-1:0]        px,
  input  logic signed [lbp3_pkg::CFG_THRESH_W-1:0] thresh,
  output logic [lbp3_pkg::CODE_W-1:0]       code
);
  import lbp3_pkg::*;

  // 0: top c-2, 1: top c-1, 2: mid c-2, 3: mid c-1 (centre), 4: bot c-2, 5: bot c-1
  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W-1:0] ctr;
  logic [CODE_W-1:0] code_raw;

  function automatic logic ge_thresh(input logic [PIX_W-1:0] nb,
                                     input logic [PIX_W-1:0] c,
                                     input logic signed [CFG_THRESH_W-1:0] th);
    logic signed [CFG_THRESH_W:0] d;
    logic signed [CFG_THRESH_W:0] t;
    d = $signed({3'b000, nb}) - $signed({3'b000, c});
    t = {th[CFG_THRESH_W-1], th};
    return d >= t;
  endfunction

  // Shift the window one column as the item leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (ctl.shift) begin
      win_r[0] <= win_r[1];
      win_r[1] <= top;
      win_r[2] <= win_r[3];
      win_r[3] <= mid;
      win_r[4] <= win_r[5];
      win_r[5] <= px;
    end
  end

  assign ctr = win_r[3];

  // Form the pattern, right first and then clockwise
  always_comb begin
    code_raw                  = '0;
    code_raw[BIT_RIGHT]       = ge_thresh(mid, ctr, thresh);
    code_raw[BIT_LOWER_RIGHT] = ge_thresh(px, ctr, thresh);
    code_raw[BIT_BELOW]       = ge_thresh(win_r[5], ctr, thresh);
    code_raw[BIT_LOWER_LEFT]  = ge_thresh(win_r[4], ctr, thresh);
    code_raw[BIT_LEFT]        = ge_thresh(win_r[2], ctr, thresh);
    code_raw[BIT_UPPER_LEFT]  = ge_thresh(win_r[0], ctr, thresh);
    code_raw[BIT_UP]          = ge_thresh(win_r[1], ctr, thresh);
    code_raw[BIT_UPPER_RIGHT] = ge_thresh(top, ctr, thresh);
  end

  assign code = ctl.border ? '0 : code_raw;

endmodule

// ----- design/lbp3_cfg_regs.sv -----
// APB-style configuration registers: width, height and threshold.
// Depends on lbp3_pkg for cfg_t, reset values and register indexes.
module lbp3_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lbp3_pkg::CFG_AW-1:0]  paddr,
  input  logic [lbp3_pkg::CFG_DW-1:0]  pwdata,
  output logic [lbp3_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output lbp3_pkg::cfg_t               cfg
);
  import lbp3_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign pready = 1'b1;

  // Write on the access cycle; unmapped words are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width    <= WIDTH_RESET;
      cfg_r.image_height   <= HEIGHT_RESET;
      cfg_r.diff_threshold <= THRESH_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  cfg_r.image_width    <= pwdata[CFG_WIDTH_W-1:0];
        REG_HEIGHT: cfg_r.image_height   <= pwdata[CFG_HEIGHT_W-1:0];
        REG_THRESH: cfg_r.diff_threshold <= pwdata[CFG_THRESH_W-1:0];
        default:    ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = CFG_DW'(cfg_r.image_width);
      REG_HEIGHT: prdata = CFG_DW'(cfg_r.image_height);
      REG_THRESH: prdata = CFG_DW'(unsigned'(cfg_r.diff_threshold));
      default:    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- design/lbp3_3x3_threshold_stream_core.sv -----
// Top level of the LBP 3x3 stream core: counters, line buffers, pipeline.
// Depends on lbp3_pkg, both channel interfaces, lbp3_line_mem, lbp3_window, lbp3_cfg_regs.
`include "assert_macros.svh"
// lbp_3x3_threshold_stream_core takes one 8-bit pixel per clock in raster order
// and, for every pixel at row r and column c with r and c both at least one,
// returns the 8-bit local binary pattern of centre (r-1, c-1) with its
// coordinates; centres in row 0 or column 0 give code 0, and the last row and
// column are never returned. Throughput is one pixel per cycle sustained while
// the output accepts results; a pixel's result is formed in the compare stage
// and held in the output register; the compare stage uses the registered read
// of both line buffers (each column entry is read as the pixel enters and
// written back as it leaves the compare stage). Line buffers need no clearing
// after reset: an entry read before it is written only feeds a border centre,
// whose code is forced to zero, as long as the image width is not raised
// part-way through a frame. Width and height saturate into [3, MAX_WIDTH] and
// [3, 4096]; write the registers only while no pixel is in flight.
module lbp_3x3_threshold_stream_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lbp3_pix_if.sink                    in_pix,
  lbp3_code_if.source                 out_code,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbp3_pkg::CFG_AW-1:0] paddr,
  input  logic [lbp3_pkg::CFG_DW-1:0] pwdata,
  output logic [lbp3_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import lbp3_pkg::*;

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EWM = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (EWM > CFG_WIDTH_W) ? EWM : CFG_WIDTH_W;

  cfg_t cfg;

  // Counters of the next pixel to arrive
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [EW-1:0]    w_ext, eff_w;
  logic [CFG_HEIGHT_W-1:0] eff_h;
  logic col_last, row_last;

  // Compare stage
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [AW-1:0]    s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [PIX_W-1:0] top_rd, mid_rd;
  logic             s1_emit, s1_adv;
  win_ctl_t         win_ctl;
  logic [CODE_W-1:0] win_code;

  // Output register
  logic              out_valid_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_free;
  logic              in_fire;
  logic [AW-1:0]     col_m1;

  lbp3_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Saturate width and height
  always_comb begin
    w_ext = EW'(cfg.image_width);
    if (w_ext < EW'(WIDTH_MIN)) begin
      eff_w = EW'(WIDTH_MIN);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    if (cfg.image_height < HEIGHT_MIN) begin
      eff_h = HEIGHT_MIN;
    end else if (cfg.image_height > HEIGHT_MAX) begin
      eff_h = HEIGHT_MAX;
    end else begin
      eff_h = cfg.image_height;
    end
  end

  assign col_last = EW'(col_r) >= (eff_w - EW'(1));
  assign row_last = CFG_HEIGHT_W'(row_r) >= (eff_h - CFG_HEIGHT_W'(1));

  // Handshake: the compare stage drains into the output register
  assign out_free     = !out_valid_r || out_code.ready;
  assign s1_emit      = (s1_row_r != '0) && (s1_col_r != '0);
  assign s1_adv       = s1_valid_r && (!s1_emit || out_free);
  assign in_pix.ready = !s1_valid_r || s1_adv;
  assign in_fire      = in_pix.valid && in_pix.ready;

  // Advance the raster counters, wrap at row and frame end
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line buffers: read at entry, write back as the item leaves the compare stage
  lbp3_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_older (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (mid_rd),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (top_rd)
  );

  lbp3_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_newer (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (mid_rd)
  );

  // Load the compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r <= in_pix.pixel;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  assign win_ctl.shift  = s1_adv;
  assign win_ctl.border = (s1_row_r < ROW_W'(2)) || (s1_col_r < AW'(2));

  lbp3_window u_win (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (win_ctl),
    .top    (top_rd),
    .mid    (mid_rd),
    .px     (s1_pix_r),
    .thresh (cfg.diff_threshold),
    .code   (win_code)
  );

  assign col_m1 = s1_col_r - AW'(1);

  // Output register: load a finished item, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_code.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_row_r  <= s1_row_r - ROW_W'(1);
      out_col_r  <= COL_W'(col_m1);
      out_code_r <= win_code;
    end
  end

  assign out_code.valid   = out_valid_r;
  assign out_code.out_row = out_row_r;
  assign out_code.out_col = out_col_r;
  assign out_code.code    = out_code_r;

  // A stalled compare stage keeps its item and its line-buffer data
  `LBP_ASSERT(a_s1_hold, s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_col_r) && $stable(top_rd) && $stable(mid_rd), "compare stage lost its item while stalled")
  // A taken pixel always lands in the compare stage
  `LBP_ASSERT(a_s1_load, in_fire |=> s1_valid_r, "accepted pixel missing from compare stage")
  // Read and write-back never hit the same line-buffer entry in one cycle
  `LBP_ASSERT_NEVER(a_no_clash, in_fire && s1_adv && (col_r == s1_col_r), "line buffer read and write on same column")
  // Centres on the first row or column carry a zero code
  `LBP_ASSERT(a_border_zero, out_valid_r && ((out_row_r == '0) || (out_col_r == '0)) |-> (out_code_r == '0), "non-zero code on border centre")

endmodule
